/* rtl/core/wssht_pkg.sv */
package wssht_pkg;

    localparam int unsigned TableSize   = 16384;
    localparam int unsigned OpWidth     = 2;
    localparam int unsigned IdWidth     = 64;
    localparam int unsigned TimeWidth   = 32;
    localparam int unsigned WinWidth    = 14;
    localparam int unsigned CountWidth  = 15;
    localparam int unsigned StatWidth   = 2;
    localparam int unsigned MarkWidth   = 2;

    localparam logic [31:0] FnvOffset = 32'd2166136261;
    localparam logic [31:0] FnvPrime  = 32'd16777619;
    localparam logic [13:0] SecPerHour = 14'd3600;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_PRUNE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [StatWidth-1:0] ST_INSERTED  = 2'd0;
    localparam logic [StatWidth-1:0] ST_REFRESHED = 2'd1;
    localparam logic [StatWidth-1:0] ST_FULL      = 2'd2;
    localparam logic [StatWidth-1:0] ST_DONE      = 2'd3;

    localparam logic [MarkWidth-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MarkWidth-1:0] MARK_LIVE  = 2'd1;
    localparam logic [MarkWidth-1:0] MARK_TOMB  = 2'd2;

    typedef struct packed {
        logic [OpWidth-1:0]   operation;
        logic signed [IdWidth-1:0] chat_id;
        logic signed [IdWidth-1:0] msg_id;
        logic [TimeWidth-1:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic [StatWidth-1:0]  status;
        logic                  present;
        logic [CountWidth-1:0] pruned_count;
        logic [CountWidth-1:0] entry_count;
    } t_out_item;

    // one FNV-1a byte round
    function automatic logic [31:0] fnv_byte(input logic [31:0] h, input logic [7:0] b);
        fnv_byte = (h ^ {24'd0, b}) * FnvPrime;
    endfunction

endpackage

/* rtl/core/wssht_if.sv */
interface wssht_in_if;
    import wssht_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wssht_out_if;
    import wssht_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wssht_cfg_if;
    logic        valid;
    logic        ready;
    logic [13:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/wssht_ram.sv */
module wssht_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/windowed_seen_set_hash_table.sv */
// Add/query: the key is hashed byte by byte, then each probed slot takes a memory
// read, then a compare and write back, and then the output register is loaded; the
// core is ready for the next transaction in the cycle that the result turns valid.
// Prune: a setup step forms the cutoff, then each table slot is read and checked.
// A waiting result holds the core in its output step only when a second one is ready.
// Reset: the mark memory is swept to empty, one slot a cycle.
module windowed_seen_set_hash_table #(
    parameter int unsigned TABLE_SIZE = wssht_pkg::TableSize
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wssht_in_if.sink    in_ch,
    wssht_out_if.source out_ch,
    wssht_cfg_if.sink   cfg_ch
);
    import wssht_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_SIZE);
    localparam int unsigned CW = AW + 1;
    localparam logic [CW-1:0] LoadLimit = CW'(TABLE_SIZE * 3 / 4);
    localparam int unsigned SlotW = 2*IdWidth + TimeWidth;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_SREAD, S_SCHECK, S_SWRITE, S_OUT
    } t_state;

    t_state                r_state;
    t_in_item              r_item;
    logic [31:0]           r_hash;
    logic [3:0]            r_byte;
    logic [AW-1:0]         r_idx;
    logic [CW-1:0]         r_steps;
    logic                  r_tomb_ok;
    logic [AW-1:0]         r_tomb;
    logic [CW-1:0]         r_live;
    logic [CW-1:0]         r_pruned;
    logic [WinWidth-1:0]   r_win;
    logic signed [33:0]    r_cutoff;
    logic [26:0]           r_span;
    logic [StatWidth-1:0]  r_status;
    logic                  r_present;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  mark_we;
    logic [AW-1:0]         mark_waddr;
    logic [MarkWidth-1:0]  mark_wdata;
    logic [MarkWidth-1:0]  mark_rdata;
    logic                  slot_we;
    logic [AW-1:0]         slot_waddr;
    logic [SlotW-1:0]      slot_wdata;
    logic [SlotW-1:0]      slot_rdata;

    logic [63:0]           s_chat;
    logic [63:0]           s_msg;
    logic [31:0]           s_stamp;
    logic [127:0]          key_bytes;
    logic [7:0]            cur_byte;
    logic [31:0]           hash_next;
    logic                  key_hit;
    logic signed [33:0]    age;
    logic                  stale;
    logic                  out_load;

    assign {s_chat, s_msg, s_stamp} = slot_rdata;
    assign key_bytes = {r_item.msg_id, r_item.chat_id};
    assign cur_byte  = key_bytes[{r_byte, 3'b000} +: 8];
    assign hash_next = fnv_byte(r_hash, cur_byte);
    assign key_hit   = (s_chat == r_item.chat_id) && (s_msg == r_item.msg_id);
    assign age       = 34'(signed'({2'b00, r_item.now_seconds})) -
                       34'(signed'({2'b00, s_stamp}));
    assign stale     = (s_stamp != '0) &&
                       (34'(signed'({2'b00, s_stamp})) < r_cutoff);
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || out_ch.ready);

    wssht_ram #(.Width(MarkWidth), .Depth(TABLE_SIZE)) u_mark (
        .i_clk  (i_clk),
        .i_we   (mark_we),
        .i_waddr(mark_waddr),
        .i_wdata(mark_wdata),
        .i_raddr(r_idx),
        .o_rdata(mark_rdata)
    );

    wssht_ram #(.Width(SlotW), .Depth(TABLE_SIZE)) u_slot (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_waddr),
        .i_wdata(slot_wdata),
        .i_raddr(r_idx),
        .o_rdata(slot_rdata)
    );

    always_comb begin
        mark_we    = 1'b0;
        mark_waddr = r_idx;
        mark_wdata = MARK_EMPTY;
        slot_we    = 1'b0;
        slot_waddr = r_idx;
        slot_wdata = {r_item.chat_id, r_item.msg_id, r_item.now_seconds};
        unique case (r_state)
            S_CLEAR: begin
                mark_we = 1'b1;
            end
            S_CHECK: begin
                if (t_op'(r_item.operation) == OP_ADD) begin
                    if (mark_rdata == MARK_LIVE && key_hit) begin
                        slot_we = 1'b1;
                    end else if (mark_rdata == MARK_EMPTY ||
                                 (r_steps == CW'(TABLE_SIZE - 1))) begin
                        // insert into first tombstone passed, else here if free
                        if (r_live < LoadLimit &&
                            (r_tomb_ok || mark_rdata != MARK_LIVE)) begin
                            slot_we    = 1'b1;
                            mark_we    = 1'b1;
                            mark_wdata = MARK_LIVE;
                            slot_waddr = r_tomb_ok ? r_tomb : r_idx;
                            mark_waddr = slot_waddr;
                        end
                    end
                end
            end
            S_SCHECK: begin
                if (mark_rdata == MARK_LIVE && stale) begin
                    mark_we    = 1'b1;
                    mark_wdata = MARK_TOMB;
                end
            end
            default: ;
        endcase
    end

    assign in_ch.ready  = (r_state == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_live      <= '0;
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_ch.valid) begin
                r_win <= cfg_ch.data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == AW'(TABLE_SIZE - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_ch.valid && in_ch.ready) begin
                        r_item    <= in_ch.data;
                        r_hash    <= FnvOffset;
                        r_byte    <= '0;
                        r_steps   <= '0;
                        r_tomb_ok <= 1'b0;
                        r_pruned  <= '0;
                        r_span    <= 27'(r_win) * 27'(SecPerHour);
                        r_status  <= ST_DONE;
                        r_present <= 1'b0;
                        unique case (t_op'(in_ch.data.operation))
                            OP_ADD, OP_QUERY: r_state <= S_HASH;
                            OP_PRUNE: begin
                                r_idx   <= '0;
                                r_state <= (r_win == '0) ? S_OUT : S_SWRITE;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_HASH: begin
                    r_hash <= hash_next;
                    r_byte <= r_byte + 1'b1;
                    if (r_byte == 4'd15) begin
                        // start slot goes to the read address before the first read
                        r_idx   <= hash_next[AW-1:0];
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (mark_rdata == MARK_LIVE && key_hit) begin
                        if (t_op'(r_item.operation) == OP_ADD) begin
                            r_status <= ST_REFRESHED;
                        end else begin
                            r_present <= (r_win == '0) || (s_stamp == '0) ||
                                         (age < 34'(signed'({7'd0, r_span})));
                        end
                        r_state <= S_OUT;
                    end else if (mark_rdata == MARK_EMPTY ||
                                 r_steps == CW'(TABLE_SIZE - 1)) begin
                        if (t_op'(r_item.operation) == OP_ADD) begin
                            if (r_live < LoadLimit &&
                                (r_tomb_ok || mark_rdata != MARK_LIVE)) begin
                                r_status <= ST_INSERTED;
                                r_live   <= r_live + 1'b1;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end
                        r_state <= S_OUT;
                    end else begin
                        if (mark_rdata == MARK_TOMB && !r_tomb_ok) begin
                            r_tomb_ok <= 1'b1;
                            r_tomb    <= r_idx;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_SWRITE: begin
                    // span settled last cycle; form the signed cutoff
                    r_cutoff <= 34'(signed'({2'b00, r_item.now_seconds})) -
                                34'(signed'({7'd0, r_span}));
                    r_state  <= S_SREAD;
                end
                S_SREAD: begin
                    r_state <= S_SCHECK;
                end
                S_SCHECK: begin
                    if (mark_rdata == MARK_LIVE && stale) begin
                        r_pruned <= r_pruned + 1'b1;
                        if (r_live != '0) begin
                            r_live <= r_live - 1'b1;
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == AW'(TABLE_SIZE - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SREAD;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_load) begin
                        r_out.status       <= r_status;
                        r_out.present      <= r_present;
                        r_out.pruned_count <= CountWidth'(r_pruned);
                        r_out.entry_count  <= CountWidth'(r_live);
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
